@@ src/fblc_pkg.sv @@
package fblc_pkg;

   localparam int SLOT_COUNT_DEF = 4;
   localparam int SLOT_BYTES_DEF = 256;

   localparam logic [7:0]  STATUS_OPCODE_RST = 8'd0;
   localparam logic [7:0]  LOAD_OPCODE_RST   = 8'd1;
   localparam logic [15:0] TIMEOUT_MS_RST    = 16'd100;

   typedef enum logic [1:0] {
      CSR_STATUS_OPCODE = 2'd0,
      CSR_LOAD_OPCODE   = 2'd1,
      CSR_TIMEOUT_MS    = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      MODE_WAIT  = 3'd0,
      MODE_LOAD  = 3'd1,
      MODE_READY = 3'd2,
      MODE_FULL  = 3'd3,
      MODE_ERROR = 3'd4,
      MODE_RECV  = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      PHASE_LEN  = 2'd0,
      PHASE_DATA = 2'd1,
      PHASE_SUM  = 2'd2
   } phase_type;

   typedef struct packed {
      logic [2:0] link_state;
      logic [2:0] slots_used;
      logic       frame_done;
      logic       frame_error;
      logic       write_valid;
      logic [1:0] write_slot;
      logic [7:0] write_offset;
      logic [7:0] write_data;
      logic [1:0] oldest_slot;
   } rsp_type;

endpackage

@@ src/framed_buffer_loader_with_checksum.sv @@
// A result is registered in the result queue on its request transfer, then offered on rsp_.
// One request per cycle while req_stall is low, each in one read-modify-write state pass.
// A two-entry result queue lets requests keep flowing while a result waits to be taken.
// Reset clears the control state, the result queue and the registers to their defaults.
// The frame length and frame payload memories are not cleared by reset.
module framed_buffer_loader_with_checksum #(
   parameter int SLOT_COUNT = fblc_pkg::SLOT_COUNT_DEF,
   parameter int SLOT_BYTES = fblc_pkg::SLOT_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_byte_present,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_ms_tick,
   input  logic        req_release_slot,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_link_state,
   output logic [2:0]  rsp_slots_used,
   output logic        rsp_frame_done,
   output logic        rsp_frame_error,
   output logic        rsp_write_valid,
   output logic [1:0]  rsp_write_slot,
   output logic [7:0]  rsp_write_offset,
   output logic [7:0]  rsp_write_data,
   output logic [1:0]  rsp_oldest_slot,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int SLOT_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CNT_W   = $clog2(SLOT_COUNT + 1);
   localparam int STORE_D = SLOT_COUNT * SLOT_BYTES;
   localparam int ADDR_W  = (STORE_D > 1) ? $clog2(STORE_D) : 1;

   logic [7:0]  status_opcode_ff;
   logic [7:0]  load_opcode_ff;
   logic [15:0] timeout_ms_ff;

   fblc_pkg::mode_type  mode_ff, mode_in, mode_cur;
   fblc_pkg::phase_type phase_ff, phase_in;
   logic [7:0]          sum_ff, sum_in;
   logic [7:0]          pos_ff, pos_in;
   logic [15:0]         time_ff, time_in;
   logic [SLOT_W-1:0]   fill_ff, fill_in;
   logic [SLOT_W-1:0]   drain_ff, drain_a;
   logic [CNT_W-1:0]    used_ff, used_in, used_a;
   logic                mark_ff, mark_in, mark_a;
   logic                len_fwd_ff;
   logic [7:0]          len_wdata_ff;

   logic        accept;
   logic        rel_ok;
   logic [15:0] time_a;
   logic        is_timeout, is_poll, is_cmd, is_load_byte;
   logic        in_len, in_data, in_sum;
   logic        load_room, sum_match, pos_fits;
   logic [7:0]  pos_next;
   logic [7:0]  len_rd_data, cur_len;
   fblc_pkg::mode_type status_mode;

   logic              len_we, store_we;
   logic [ADDR_W-1:0] store_addr;
   logic              done, err;
   fblc_pkg::rsp_type res;

   fblc_pkg::rsp_type q_ff [2];
   logic              wr_ptr_ff, rd_ptr_ff;
   logic [1:0]        count_ff;
   logic              pop;

   assign req_stall = (count_ff == 2'd2);
   assign accept    = req_valid && !req_stall;
   assign pop       = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         status_opcode_ff <= fblc_pkg::STATUS_OPCODE_RST;
         load_opcode_ff   <= fblc_pkg::LOAD_OPCODE_RST;
         timeout_ms_ff    <= fblc_pkg::TIMEOUT_MS_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            fblc_pkg::CSR_STATUS_OPCODE: status_opcode_ff <= csr_wdata[7:0];
            fblc_pkg::CSR_LOAD_OPCODE:   load_opcode_ff   <= csr_wdata[7:0];
            fblc_pkg::CSR_TIMEOUT_MS:    timeout_ms_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (mode_ff)
         fblc_pkg::MODE_LOAD:  mode_cur = fblc_pkg::MODE_LOAD;
         fblc_pkg::MODE_READY: mode_cur = fblc_pkg::MODE_READY;
         fblc_pkg::MODE_FULL:  mode_cur = fblc_pkg::MODE_FULL;
         fblc_pkg::MODE_ERROR: mode_cur = fblc_pkg::MODE_ERROR;
         fblc_pkg::MODE_RECV:  mode_cur = fblc_pkg::MODE_RECV;
         default:              mode_cur = fblc_pkg::MODE_WAIT;
      endcase
   end

   // The release is applied before anything else in the same transfer.
   assign rel_ok  = req_release_slot && (used_ff != '0);
   assign used_a  = rel_ok ? used_ff - CNT_W'(1) : used_ff;
   assign mark_a  = rel_ok ? 1'b1 : mark_ff;
   assign drain_a = !rel_ok ? drain_ff :
                    (drain_ff == SLOT_W'(SLOT_COUNT - 1)) ? '0 : drain_ff + SLOT_W'(1);
   assign time_a  = (mode_cur == fblc_pkg::MODE_LOAD && req_ms_tick && time_ff != '0) ?
                    time_ff - 16'd1 : time_ff;

   assign is_timeout   = (mode_cur == fblc_pkg::MODE_LOAD) && (time_a == '0);
   assign is_poll      = !is_timeout && !req_byte_present;
   assign is_cmd       = !is_timeout && req_byte_present && (mode_cur != fblc_pkg::MODE_LOAD);
   assign is_load_byte = !is_timeout && req_byte_present && (mode_cur == fblc_pkg::MODE_LOAD);

   assign in_len  = (phase_ff == fblc_pkg::PHASE_LEN);
   assign in_data = (phase_ff == fblc_pkg::PHASE_DATA);
   assign in_sum  = !in_len && !in_data;

   assign load_room   = ({{(32-CNT_W){1'b0}}, used_a} < 32'(SLOT_COUNT));
   assign status_mode = load_room ? fblc_pkg::MODE_READY : fblc_pkg::MODE_FULL;
   assign sum_match   = (sum_ff == req_rx_byte);
   assign pos_fits    = ({1'b0, pos_ff} < 9'(SLOT_BYTES));
   assign pos_next    = pos_ff + 8'd1;

   // The length entry written by the previous transfer is not yet visible at the read port.
   assign cur_len = len_fwd_ff ? len_wdata_ff : len_rd_data;

   always_comb begin
      mode_in  = mode_cur;
      phase_in = phase_ff;
      sum_in   = sum_ff;
      pos_in   = pos_ff;
      time_in  = time_a;
      fill_in  = fill_ff;
      used_in  = used_a;
      mark_in  = mark_a;
      if (is_timeout) begin
         mode_in = fblc_pkg::MODE_ERROR;
      end else if (is_poll) begin
         unique case (mode_cur)
            fblc_pkg::MODE_WAIT: begin
               if (mark_a) begin
                  mode_in = status_mode;
                  mark_in = 1'b0;
               end
            end
            fblc_pkg::MODE_READY, fblc_pkg::MODE_FULL: mode_in = fblc_pkg::MODE_WAIT;
            fblc_pkg::MODE_ERROR, fblc_pkg::MODE_RECV: mode_in = status_mode;
            default: ;
         endcase
      end else if (is_cmd) begin
         mode_in = fblc_pkg::MODE_WAIT;
         if (req_rx_byte == status_opcode_ff) begin
            mode_in = status_mode;
         end
         if (req_rx_byte == load_opcode_ff) begin
            if (load_room) begin
               mode_in  = fblc_pkg::MODE_LOAD;
               phase_in = fblc_pkg::PHASE_LEN;
               time_in  = timeout_ms_ff;
            end else begin
               mode_in = fblc_pkg::MODE_ERROR;
            end
         end
      end else begin
         time_in = timeout_ms_ff;
         if (in_len) begin
            sum_in   = req_rx_byte;
            pos_in   = '0;
            phase_in = (req_rx_byte == '0) ? fblc_pkg::PHASE_SUM : fblc_pkg::PHASE_DATA;
         end else if (in_data) begin
            sum_in = sum_ff + req_rx_byte;
            pos_in = pos_next;
            if (pos_next == cur_len) begin
               phase_in = fblc_pkg::PHASE_SUM;
            end
         end else if (sum_match) begin
            fill_in = (fill_ff == SLOT_W'(SLOT_COUNT - 1)) ? '0 : fill_ff + SLOT_W'(1);
            if (load_room) begin
               used_in = used_a + CNT_W'(1);
            end
            mode_in = fblc_pkg::MODE_RECV;
         end else begin
            mode_in = fblc_pkg::MODE_ERROR;
         end
      end
   end

   always_comb begin
      done     = is_load_byte && in_sum && sum_match;
      err      = is_timeout
               || (is_cmd && req_rx_byte == load_opcode_ff && !load_room)
               || (is_load_byte && in_sum && !sum_match);
      len_we   = accept && is_load_byte && in_len;
      store_we = accept && is_load_byte && in_data && pos_fits;
      res.link_state   = 3'(mode_in);
      res.slots_used   = 3'(used_in);
      res.frame_done   = done;
      res.frame_error  = err;
      res.write_valid  = 1'b0;
      res.write_slot   = '0;
      res.write_offset = '0;
      res.write_data   = '0;
      res.oldest_slot  = 2'(drain_a);
      if (is_load_byte && in_data && pos_fits) begin
         res.write_valid  = 1'b1;
         res.write_slot   = 2'(fill_ff);
         res.write_offset = pos_ff;
         res.write_data   = req_rx_byte;
      end
   end

   assign store_addr = ADDR_W'(32'(fill_ff) * SLOT_BYTES + 32'(pos_ff));

   fblc_ram #(
      .WIDTH(8),
      .DEPTH(SLOT_COUNT)
   ) u_len_ram (
      .clock   (clock),
      .wr_en   (len_we),
      .wr_addr (fill_ff),
      .wr_data (req_rx_byte),
      .rd_addr (fill_ff),
      .rd_data (len_rd_data)
   );

   fblc_ram #(
      .WIDTH(8),
      .DEPTH(STORE_D)
   ) u_store_ram (
      .clock   (clock),
      .wr_en   (store_we),
      .wr_addr (store_addr),
      .wr_data (req_rx_byte),
      .rd_addr (store_addr),
      .rd_data ()
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= fblc_pkg::MODE_WAIT;
         phase_ff   <= fblc_pkg::PHASE_LEN;
         sum_ff     <= '0;
         pos_ff     <= '0;
         time_ff    <= '0;
         fill_ff    <= '0;
         drain_ff   <= '0;
         used_ff    <= '0;
         mark_ff    <= 1'b0;
         len_fwd_ff <= 1'b0;
      end else begin
         len_fwd_ff <= len_we;
         if (accept) begin
            mode_ff  <= mode_in;
            phase_ff <= phase_in;
            sum_ff   <= sum_in;
            pos_ff   <= pos_in;
            time_ff  <= time_in;
            fill_ff  <= fill_in;
            drain_ff <= drain_a;
            used_ff  <= used_in;
            mark_ff  <= mark_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (len_we) begin
         len_wdata_ff <= req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (accept) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (accept && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !accept) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff[wr_ptr_ff] <= res;
      end
   end

   assign rsp_valid        = (count_ff != '0);
   assign rsp_link_state   = q_ff[rd_ptr_ff].link_state;
   assign rsp_slots_used   = q_ff[rd_ptr_ff].slots_used;
   assign rsp_frame_done   = q_ff[rd_ptr_ff].frame_done;
   assign rsp_frame_error  = q_ff[rd_ptr_ff].frame_error;
   assign rsp_write_valid  = q_ff[rd_ptr_ff].write_valid;
   assign rsp_write_slot   = q_ff[rd_ptr_ff].write_slot;
   assign rsp_write_offset = q_ff[rd_ptr_ff].write_offset;
   assign rsp_write_data   = q_ff[rd_ptr_ff].write_data;
   assign rsp_oldest_slot  = q_ff[rd_ptr_ff].oldest_slot;

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      {{(32-CNT_W){1'b0}}, used_ff} <= 32'(SLOT_COUNT))
      else $error("Committed slot count exceeds the ring size.");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("Result queue count is out of range.");

   a_done_err: assert property (@(posedge clock) disable iff (reset)
      accept |-> !(done && err))
      else $error("A transfer both committed a frame and raised an error.");

   a_commit_used: assert property (@(posedge clock) disable iff (reset)
      (accept && done) |=> (used_ff != '0) && (mode_ff == fblc_pkg::MODE_RECV))
      else $error("A committed frame left the ring empty or the mode wrong.");

endmodule

@@ src/fblc_ram.sv @@
module fblc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
